/* sv/csma_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csma_pkg
// Shared types and constants for the shared-bus transmit node.
// ----------------------------------------------------------------------------
package csma_pkg;

  localparam int FrameBits = 256;
  localparam int AddrBits  = $clog2(FrameBits);
  localparam int PosBits   = AddrBits + 1;
  localparam int MaxRetry  = 15;

  localparam logic [11:0] GapReset   = 12'd96;
  localparam logic [11:0] JamReset   = 12'd48;
  localparam logic [3:0]  ScaleReset = 4'd10;

  // register indexes on the configuration port
  localparam logic [1:0] REG_GAP   = 2'd0;
  localparam logic [1:0] REG_JAM   = 2'd1;
  localparam logic [1:0] REG_SCALE = 2'd2;

  // observed bus values
  localparam logic [1:0] BUS_IDLE = 2'd2;
  localparam logic [1:0] BUS_JAM  = 2'd3;

  // drive codes
  localparam logic [2:0] DRV_NONE    = 3'd0;
  localparam logic [2:0] DRV_ZERO    = 3'd1;
  localparam logic [2:0] DRV_RELEASE = 3'd3;
  localparam logic [2:0] DRV_JAM     = 3'd4;

  localparam logic REQ_LOAD = 1'b1;

  typedef enum logic [1:0] {
    PH_LISTEN  = 2'd0,
    PH_SEND    = 2'd1,
    PH_JAM     = 2'd2,
    PH_BACKOFF = 2'd3
  } phase_t;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  bus_seen;
    logic [15:0] random_draw;
    logic [7:0]  load_index;
    logic        load_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0] drive_code;
    logic [1:0] node_phase;
    logic [3:0] retry_count;
    logic       frame_done;
  } out_word_t;

  typedef struct packed {
    logic [11:0] interframe_gap;
    logic [11:0] jam_length;
    logic [3:0]  backoff_scale;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic lim;
    logic mul;
    logic commit;
  } dp_cmd_t;

endpackage

/* sv/csma_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csma_regs
// Configuration register file behind a simple APB-style slave port.
// ----------------------------------------------------------------------------
module csma_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output csma_pkg::cfg_t cfg
);
  import csma_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interframe_gap <= GapReset;
      cfg.jam_length     <= JamReset;
      cfg.backoff_scale  <= ScaleReset;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GAP:   cfg.interframe_gap <= pwdata[11:0];
        REG_JAM:   cfg.jam_length     <= pwdata[11:0];
        REG_SCALE: cfg.backoff_scale  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAP:   prdata = {20'd0, cfg.interframe_gap};
      REG_JAM:   prdata = {20'd0, cfg.jam_length};
      REG_SCALE: prdata = {28'd0, cfg.backoff_scale};
      default:   prdata = 32'd0;
    endcase
  end

endmodule

/* sv/csma_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csma_ctrl
// Sequencer: capture a word, run the backoff multiply steps, commit the result.
// ----------------------------------------------------------------------------
module csma_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output csma_pkg::dp_cmd_t cmd
);
  import csma_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LIM  = 4'b0010,
    S_MUL  = 4'b0100,
    S_DONE = 4'b1000
  } ctrl_state_t;

  ctrl_state_t state, state_next;

  assign in_ready    = (state == S_IDLE);
  assign cmd.capture = in_valid & in_ready;
  assign cmd.lim     = (state == S_LIM);
  assign cmd.mul     = (state == S_MUL);
  // commit only once the output slot is free
  assign cmd.commit  = (state == S_DONE) & (~out_valid | out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (cmd.capture) state_next = S_LIM;
      S_LIM:  state_next = S_MUL;
      S_MUL:  state_next = S_DONE;
      S_DONE: if (cmd.commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* sv/csma_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csma_dp
// Node state, frame bit store, backoff delay multiplier and result register.
// ----------------------------------------------------------------------------
module csma_dp (
  input  logic                clk,
  input  logic                rst,
  input  csma_pkg::dp_cmd_t   cmd,
  input  csma_pkg::cfg_t      cfg,
  input  csma_pkg::in_word_t  in_data,
  output csma_pkg::out_word_t out_data
);
  import csma_pkg::*;

  logic frame_mem [FrameBits];

  // architectural state
  phase_t               phase, phase_next;
  logic [11:0]          countdown, countdown_next;
  logic [PosBits-1:0]   bit_pos, bit_pos_next;
  logic [3:0]           retries, retries_next;

  // per-word working registers
  in_word_t             item;
  logic                 prev_bit;
  logic                 cur_bit;
  logic [7:0]           sq;
  logic [11:0]          lim1;
  logic [11:0]          delay;

  logic                 expiry_cap;
  logic                 jam_hit_cap;
  logic [3:0]           retries_bumped;
  logic [3:0]           retries_bo;
  logic [11:0]          lim_prod;
  logic [27:0]          draw_prod;
  logic [AddrBits-1:0]  prev_addr;
  logic [AddrBits-1:0]  cur_addr;

  logic [2:0]           drive;
  logic                 done;
  logic                 collided;

  assign retries_bumped = (retries < 4'(MaxRetry)) ? retries + 4'd1 : retries;

  // which backoff branch the incoming word will take; state is stable until commit
  assign expiry_cap  = (countdown == 12'd0) && (phase != PH_SEND);
  assign jam_hit_cap = (in_data.bus_seen == BUS_JAM) &&
                       ((phase == PH_LISTEN) || (phase == PH_SEND));
  assign retries_bo  = (!expiry_cap && jam_hit_cap) ? retries_bumped : retries;

  assign prev_addr = AddrBits'(bit_pos - PosBits'(1));
  assign cur_addr  = bit_pos[AddrBits-1:0];

  assign lim_prod  = 12'(cfg.backoff_scale) * 12'(sq);
  assign draw_prod = 28'(item.random_draw) * 28'(lim1);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item     <= in_data;
      prev_bit <= frame_mem[prev_addr];
      cur_bit  <= frame_mem[cur_addr];
      sq       <= 8'(retries_bo) * 8'(retries_bo);
      if (in_data.req_type == REQ_LOAD) begin
        frame_mem[in_data.load_index[AddrBits-1:0]] <= in_data.load_value;
      end
    end
    if (cmd.lim) begin
      lim1 <= lim_prod + 12'd1;
    end
    if (cmd.mul) begin
      delay <= draw_prod[27:16];
    end
  end

  always_comb begin
    phase_next     = phase;
    countdown_next = countdown;
    bit_pos_next   = bit_pos;
    retries_next   = retries;
    drive          = DRV_NONE;
    done           = 1'b0;
    collided       = (bit_pos != '0) && (bit_pos <= PosBits'(FrameBits)) &&
                     (item.bus_seen != BUS_IDLE) &&
                     (item.bus_seen != {1'b0, prev_bit});
    if (item.req_type == REQ_LOAD) begin
      // load only touches the store
    end else if ((countdown == 12'd0) && (phase != PH_SEND)) begin
      case (phase)
        PH_LISTEN: begin
          bit_pos_next   = '0;
          phase_next     = PH_SEND;
          countdown_next = 12'd1;
        end
        PH_BACKOFF: begin
          bit_pos_next   = '0;
          countdown_next = cfg.interframe_gap;
          phase_next     = PH_LISTEN;
        end
        default: begin
          phase_next     = PH_BACKOFF;
          countdown_next = delay;
          drive          = DRV_RELEASE;
        end
      endcase
    end else if ((item.bus_seen == BUS_JAM) && (phase inside {PH_LISTEN, PH_SEND})) begin
      retries_next   = retries_bumped;
      phase_next     = PH_BACKOFF;
      countdown_next = delay;
    end else begin
      case (phase)
        PH_LISTEN: begin
          if (item.bus_seen == BUS_IDLE) countdown_next = countdown - 12'd1;
        end
        PH_SEND: begin
          if (collided) begin
            phase_next     = PH_JAM;
            countdown_next = cfg.jam_length;
            retries_next   = retries_bumped;
          end else if (bit_pos >= PosBits'(FrameBits)) begin
            phase_next     = PH_LISTEN;
            drive          = DRV_RELEASE;
            countdown_next = cfg.interframe_gap;
            retries_next   = 4'd0;
            done           = 1'b1;
          end else begin
            drive        = DRV_ZERO + 3'(cur_bit);
            bit_pos_next = bit_pos + PosBits'(1);
          end
        end
        PH_JAM: begin
          drive          = DRV_JAM;
          countdown_next = countdown - 12'd1;
        end
        default: countdown_next = countdown - 12'd1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LISTEN;
      countdown <= GapReset;
      bit_pos   <= '0;
      retries   <= 4'd0;
    end else if (cmd.commit) begin
      phase     <= phase_next;
      countdown <= countdown_next;
      bit_pos   <= bit_pos_next;
      retries   <= retries_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.drive_code  <= drive;
      out_data.node_phase  <= phase_next;
      out_data.retry_count <= retries_next;
      out_data.frame_done  <= done;
    end
  end

endmodule

/* sv/csma_cd_transmit_node.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csma_cd_transmit_node
// Shared-bus transmit node with carrier sense, collision detect and backoff.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid/in_ready, in_data) are either a bit tick carrying
//   the observed bus value and a random draw, or a load of one frame bit.
//   Every input word yields exactly one output word (out_valid/out_ready,
//   out_data) with the drive code, the phase and retry count after the word
//   and a frame-done flag.
//   A word is accepted in S_IDLE, then steps through S_LIM, S_MUL and S_DONE,
//   where out_valid is registered at commit; one word is in flight at a time.
//   The steps are the backoff delay path: retries squared, times the scale,
//   times the 16-bit draw, one registered multiply per cycle.
//   If the receiver stalls, the finished word waits in the output register;
//   the next word can already be accepted and worked on, and it stops in
//   its final step until the output register frees up.
//   Reset (rst, synchronous) returns the node to listening with the gap
//   count at 96, retries zero and default registers. The frame store is
//   not cleared: load every bit before the frame is sent.
//   Configuration writes go through the APB-style port; write them only while idle (the block does not enforce it).
// ----------------------------------------------------------------------------
module csma_cd_transmit_node (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  csma_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output csma_pkg::out_word_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import csma_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;

  csma_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  csma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  csma_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_data  (in_data),
    .out_data (out_data)
  );

  // one word in flight: no acceptance right after a capture
  a_single_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a word while the previous one was in flight");

  a_jam_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.drive_code == DRV_JAM) |-> (out_data.node_phase == PH_JAM))
    else $error("jam driven outside the jamming phase");

  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_done |->
      (out_data.node_phase == PH_LISTEN) && (out_data.retry_count == 4'd0) &&
      (out_data.drive_code == DRV_RELEASE))
    else $error("frame done without release to listening");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.drive_code <= DRV_JAM))
    else $error("drive code out of range");

endmodule
